FILE: sv/ckm_pkg.sv
// Shared types, register indexes and constants for the chroma key pixel mixer.
`timescale 1ns / 1ps
`default_nettype none
package ckm_pkg;

  typedef enum logic [2:0] {
    REG_KEY_CB_UNIT         = 3'd0,
    REG_KEY_CR_UNIT         = 3'd1,
    REG_ACCEPT_TANGENT      = 3'd2,
    REG_ACCEPT_COTANGENT    = 3'd3,
    REG_INVERSE_KEY_GAIN    = 3'd4,
    REG_LUMA_SUPPRESS_SCALE = 3'd5,
    REG_KEY_MAGNITUDE       = 3'd6,
    REG_NOISE_THRESHOLD     = 3'd7
  } cfg_idx_t;

  localparam int CfgDataW = 16;

  localparam logic [7:0] NoiseLuma   = 8'd16;
  localparam logic [7:0] NoiseChroma = 8'd128;
  localparam logic [7:0] FullBg      = 8'd255;
  localparam logic signed [8:0] ChromaOffset = 9'sd128;

  typedef struct packed {
    logic signed [7:0] key_cb_unit;
    logic signed [7:0] key_cr_unit;
    logic [11:0]       accept_tangent;
    logic [11:0]       accept_cotangent;
    logic signed [8:0] inverse_key_gain;
    logic [7:0]        luma_suppress_scale;
    logic [8:0]        key_magnitude;
    logic [15:0]       noise_threshold;
  } cfg_t;

  typedef struct packed {
    logic [7:0] fg_luma;
    logic [7:0] fg_blue_diff;
    logic [7:0] fg_red_diff;
    logic [7:0] bg_luma;
    logic [7:0] bg_blue_diff;
    logic [7:0] bg_red_diff;
  } pix_t;

  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] z;
    pix_t              pix;
  } rot_t;

  typedef struct packed {
    logic signed [7:0] x;
    logic signed [7:0] z;
    logic [7:0]        e;
    logic [6:0]        bound;
    logic [7:0]        absz;
    logic [7:0]        n;
    pix_t              pix;
  } wedge_t;

  typedef struct packed {
    logic       keyed;
    logic [7:0] kbg;
    logic [7:0] ly;
    logic [7:0] lu;
    logic [7:0] lv;
    pix_t       pix;
  } key_t;

  function automatic logic signed [7:0] clamp_s8(input logic signed [10:0] v);
    logic signed [7:0] r;
    if (v < -11'sd128) begin
      r = -8'sd128;
    end else if (v > 11'sd127) begin
      r = 8'sd127;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/ckm_rotate.sv
// Stage one: rotates foreground chroma into key-aligned X and Z coordinates.
`timescale 1ns / 1ps
`default_nettype none
module ckm_rotate (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ckm_pkg::cfg_t cfg,
  input  wire ckm_pkg::pix_t pix,
  output ckm_pkg::rot_t      q_r
);
  import ckm_pkg::*;

  logic signed [8:0]  fu_s;
  logic signed [8:0]  fv_s;
  logic signed [16:0] p_ucb;
  logic signed [16:0] p_vcr;
  logic signed [16:0] p_vcb;
  logic signed [16:0] p_ucr;
  logic signed [17:0] sx;
  logic signed [17:0] sz;
  rot_t               q_nxt;

  always_comb begin
    fu_s  = $signed({1'b0, pix.fg_blue_diff});
    fv_s  = $signed({1'b0, pix.fg_red_diff});
    p_ucb = fu_s * cfg.key_cb_unit;
    p_vcr = fv_s * cfg.key_cr_unit;
    p_vcb = fv_s * cfg.key_cb_unit;
    p_ucr = fu_s * cfg.key_cr_unit;
    sx    = 18'(p_ucb) + 18'(p_vcr);
    sz    = 18'(p_vcb) - 18'(p_ucr);
    q_nxt.x   = clamp_s8($signed(sx[17:7]));
    q_nxt.z   = clamp_s8($signed(sz[17:7]));
    q_nxt.pix = pix;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ckm_wedge.sv
// Stage two: wedge bound, wedge edge, absolute Z and noise distance.
`timescale 1ns / 1ps
`default_nettype none
module ckm_wedge (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ckm_pkg::cfg_t cfg,
  input  wire ckm_pkg::rot_t d,
  output ckm_pkg::wedge_t    q_r
);
  import ckm_pkg::*;

  logic signed [20:0] p_bound;
  logic signed [20:0] p_edge;
  logic signed [15:0] p_zz;
  logic [15:0]        p_km;
  logic [7:0]         b8;
  logic [7:0]         zu;
  wedge_t             q_nxt;

  always_comb begin
    p_bound = d.x * $signed({1'b0, cfg.accept_tangent});
    p_edge  = d.z * $signed({1'b0, cfg.accept_cotangent});
    p_zz    = d.z * d.z;
    p_km    = cfg.key_magnitude[7:0] * cfg.key_magnitude[7:0];
    b8      = p_bound[11:4];
    zu      = d.z;
    q_nxt.x     = d.x;
    q_nxt.z     = d.z;
    q_nxt.e     = p_edge[11:4];
    q_nxt.bound = b8[7] ? 7'h7f : b8[6:0];
    q_nxt.absz  = zu[7] ? (~zu + 8'd1) : zu;
    q_nxt.n     = p_zz[7:0] + p_km[7:0];
    q_nxt.pix   = d.pix;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ckm_key.sv
// Stage three: key decision, key factor, suppressed luma and rebuilt chroma.
`timescale 1ns / 1ps
`default_nettype none
module ckm_key (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire ckm_pkg::cfg_t   cfg,
  input  wire ckm_pkg::wedge_t d,
  output ckm_pkg::key_t        q_r
);
  import ckm_pkg::*;

  logic [7:0]         dd;
  logic [7:0]         xu;
  logic signed [17:0] p_gain;
  logic signed [16:0] kb;
  logic [15:0]        p_luma;
  logic signed [8:0]  kcbm;
  logic signed [8:0]  kcrm;
  logic signed [8:0]  e_s;
  logic signed [17:0] p_ecb;
  logic signed [17:0] p_ecr;
  logic signed [16:0] p_zcr;
  logic signed [16:0] p_zcb;
  logic signed [18:0] su;
  logic signed [18:0] sv;
  logic               noise;
  key_t               q_nxt;

  always_comb begin
    xu     = d.x;
    dd     = xu - d.e;
    p_gain = cfg.inverse_key_gain * $signed({1'b0, dd});
    kb     = $signed(p_gain[17:1]);
    p_luma = dd * cfg.luma_suppress_scale;
    kcbm   = $signed({cfg.key_cb_unit[7], cfg.key_cb_unit}) - ChromaOffset;
    kcrm   = $signed({cfg.key_cr_unit[7], cfg.key_cr_unit}) - ChromaOffset;
    e_s    = $signed({1'b0, d.e});
    p_ecb  = e_s * kcbm;
    p_ecr  = e_s * kcrm;
    p_zcr  = d.z * kcrm;
    p_zcb  = d.z * kcbm;
    su     = 19'(p_ecb) - 19'(p_zcr);
    sv     = 19'(p_ecr) - 19'(p_zcb);
    noise  = {8'd0, d.n} < cfg.noise_threshold;

    q_nxt.keyed = {1'b0, d.absz} < {2'b00, d.bound};
    q_nxt.pix   = d.pix;
    if (noise) begin
      q_nxt.kbg = FullBg;
      q_nxt.ly  = NoiseLuma;
      q_nxt.lu  = NoiseChroma;
      q_nxt.lv  = NoiseChroma;
    end else begin
      if (kb < 17'sd0) begin
        q_nxt.kbg = 8'd0;
      end else if (kb > 17'sd255) begin
        q_nxt.kbg = FullBg;
      end else begin
        q_nxt.kbg = kb[7:0];
      end
      q_nxt.ly = d.pix.fg_luma - p_luma[11:4];
      q_nxt.lu = su[14:7];
      q_nxt.lv = sv[14:7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/ckm_mix.sv
// Stage four: background mix for keyed pixels, foreground pass for the rest.
`timescale 1ns / 1ps
`default_nettype none
module ckm_mix (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire ckm_pkg::key_t d,
  output logic [7:0]         luma_r,
  output logic [7:0]         blue_r,
  output logic [7:0]         red_r
);
  import ckm_pkg::*;

  logic [15:0] p_y;
  logic [15:0] p_u;
  logic [15:0] p_v;
  logic [16:0] s_y;
  logic [16:0] s_u;
  logic [16:0] s_v;
  logic [7:0]  luma_nxt;
  logic [7:0]  blue_nxt;
  logic [7:0]  red_nxt;

  always_comb begin
    p_y = d.kbg * d.pix.bg_luma;
    p_u = d.kbg * d.pix.bg_blue_diff;
    p_v = d.kbg * d.pix.bg_red_diff;
    s_y = {9'd0, d.ly} + {1'b0, p_y};
    s_u = {9'd0, d.lu} + {1'b0, p_u};
    s_v = {9'd0, d.lv} + {1'b0, p_v};
    if (d.keyed) begin
      luma_nxt = s_y[15:8];
      blue_nxt = s_u[15:8];
      red_nxt  = s_v[15:8];
    end else begin
      luma_nxt = d.pix.fg_luma;
      blue_nxt = d.pix.fg_blue_diff;
      red_nxt  = d.pix.fg_red_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      luma_r <= luma_nxt;
      blue_r <= blue_nxt;
      red_r  <= red_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/chroma_key_pixel_mixer.sv
// Top level of the chroma key pixel mixer: registers, stage control and stages.
// An accepted word passes the rotate, wedge, key and mix registers in order.
// Throughput is one word per cycle with out_ready high; each of the four stages
// holds one word and moves it on when the stage after it is empty or moving.
// Reset clears the stage valid bits and loads the key registers with defaults.
`timescale 1ns / 1ps
`default_nettype none
module chroma_key_pixel_mixer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_fg_luma,
  input  wire logic [7:0]  in_fg_blue_diff,
  input  wire logic [7:0]  in_fg_red_diff,
  input  wire logic [7:0]  in_bg_luma,
  input  wire logic [7:0]  in_bg_blue_diff,
  input  wire logic [7:0]  in_bg_red_diff,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_luma,
  output logic [7:0]       out_blue_diff,
  output logic [7:0]       out_red_diff
);
  import ckm_pkg::*;

  cfg_t   cfg_r;
  pix_t   pix;
  rot_t   rot_q;
  wedge_t wedge_q;
  key_t   key_q;
  logic   v1_r;
  logic   v2_r;
  logic   v3_r;
  logic   v4_r;
  logic   adv1;
  logic   adv2;
  logic   adv3;
  logic   adv4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.key_cb_unit         <= 8'sd90;
      cfg_r.key_cr_unit         <= 8'sd90;
      cfg_r.accept_tangent      <= 12'd4;
      cfg_r.accept_cotangent    <= 12'd55;
      cfg_r.inverse_key_gain    <= -9'sd252;
      cfg_r.luma_suppress_scale <= 8'd1;
      cfg_r.key_magnitude       <= 9'd181;
      cfg_r.noise_threshold     <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_KEY_CB_UNIT:         cfg_r.key_cb_unit         <= cfg_data[7:0];
        REG_KEY_CR_UNIT:         cfg_r.key_cr_unit         <= cfg_data[7:0];
        REG_ACCEPT_TANGENT:      cfg_r.accept_tangent      <= cfg_data[11:0];
        REG_ACCEPT_COTANGENT:    cfg_r.accept_cotangent    <= cfg_data[11:0];
        REG_INVERSE_KEY_GAIN:    cfg_r.inverse_key_gain    <= cfg_data[8:0];
        REG_LUMA_SUPPRESS_SCALE: cfg_r.luma_suppress_scale <= cfg_data[7:0];
        REG_KEY_MAGNITUDE:       cfg_r.key_magnitude       <= cfg_data[8:0];
        REG_NOISE_THRESHOLD:     cfg_r.noise_threshold     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign adv4      = !v4_r || out_ready;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_ready  = adv1;
  assign out_valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_comb begin
    pix.fg_luma      = in_fg_luma;
    pix.fg_blue_diff = in_fg_blue_diff;
    pix.fg_red_diff  = in_fg_red_diff;
    pix.bg_luma      = in_bg_luma;
    pix.bg_blue_diff = in_bg_blue_diff;
    pix.bg_red_diff  = in_bg_red_diff;
  end

  ckm_rotate u_rotate (
    .clk (clk),
    .en  (adv1 && in_valid),
    .cfg (cfg_r),
    .pix (pix),
    .q_r (rot_q)
  );

  ckm_wedge u_wedge (
    .clk (clk),
    .en  (adv2 && v1_r),
    .cfg (cfg_r),
    .d   (rot_q),
    .q_r (wedge_q)
  );

  ckm_key u_key (
    .clk (clk),
    .en  (adv3 && v2_r),
    .cfg (cfg_r),
    .d   (wedge_q),
    .q_r (key_q)
  );

  ckm_mix u_mix (
    .clk    (clk),
    .en     (adv4 && v3_r),
    .d      (key_q),
    .luma_r (out_luma),
    .blue_r (out_blue_diff),
    .red_r  (out_red_diff)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the chroma key pixel mixer with random handshake pacing.
`timescale 1ns / 1ps
module tb;
  import ckm_pkg::*;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
  } keyed_pix_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  cfg_idx_t            cfg_index = REG_KEY_CB_UNIT;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  pix_t                offered = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_luma;
  logic [7:0]          out_blue_diff;
  logic [7:0]          out_red_diff;

  pix_t       pending_pixels[$];
  keyed_pix_t expected_pixels[$];

  int k_cb = 90;
  int k_cr = 90;
  int k_tan = 4;
  int k_cot = 55;
  int k_gain = -252;
  int k_scale = 1;
  int k_mag = 181;
  int k_thr = 1;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   send_wait = 0;
  int   recv_wait = 0;
  int   send_idle_max = 0;
  int   recv_idle_max = 0;
  logic squeeze = 1'b0;
  logic squeeze_go = 1'b0;
  int   pixels_queued = 0;
  int   pixels_checked = 0;
  int   mismatches = 0;

  chroma_key_pixel_mixer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_fg_luma     (offered.fg_luma),
    .in_fg_blue_diff(offered.fg_blue_diff),
    .in_fg_red_diff (offered.fg_red_diff),
    .in_bg_luma     (offered.bg_luma),
    .in_bg_blue_diff(offered.bg_blue_diff),
    .in_bg_red_diff (offered.bg_red_diff),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_luma       (out_luma),
    .out_blue_diff  (out_blue_diff),
    .out_red_diff   (out_red_diff)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic keyed_pix_t key_mix(input pix_t p, output bit keyed);
    int x, z, bound, absz, e, d, kbg, ly, lu, lv, n;
    keyed_pix_t r;
    x = clip((int'(p.fg_blue_diff) * k_cb + int'(p.fg_red_diff) * k_cr) >>> 7, -128, 127);
    z = clip((int'(p.fg_red_diff) * k_cb - int'(p.fg_blue_diff) * k_cr) >>> 7, -128, 127);
    bound = ((x * k_tan) >>> 4) & 255;
    if (bound > 127) begin
      bound = 127;
    end
    absz = (z < 0) ? -z : z;
    keyed = absz < bound;
    if (keyed) begin
      e = ((z * k_cot) >>> 4) & 255;
      d = (x - e) & 255;
      kbg = clip((d * k_gain) >>> 1, 0, 255);
      ly = (int'(p.fg_luma) - (((d * k_scale) >>> 4) & 255)) & 255;
      lu = ((e * (k_cb - 128) - z * (k_cr - 128)) >>> 7) & 255;
      lv = ((e * (k_cr - 128) - z * (k_cb - 128)) >>> 7) & 255;
      n = (z * z + k_mag * k_mag) & 255;
      if (n < k_thr) begin
        ly = int'(NoiseLuma);
        lu = int'(NoiseChroma);
        lv = int'(NoiseChroma);
        kbg = int'(FullBg);
      end
      r.luma = 8'((ly + kbg * int'(p.bg_luma)) >> 8);
      r.blue_diff = 8'((lu + kbg * int'(p.bg_blue_diff)) >> 8);
      r.red_diff = 8'((lv + kbg * int'(p.bg_red_diff)) >> 8);
    end else begin
      r.luma = p.fg_luma;
      r.blue_diff = p.fg_blue_diff;
      r.red_diff = p.fg_red_diff;
    end
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Keyed pixels are found by drawing up to 64 times until one lands inside the wedge.
  function automatic pix_t draw_pixel(input bit want_keyed);
    pix_t p;
    keyed_pix_t unused;
    bit hit;
    for (int tries = 0; tries < 64; tries++) begin
      p.fg_luma = rand_byte();
      p.fg_blue_diff = rand_byte();
      p.fg_red_diff = rand_byte();
      p.bg_luma = rand_byte();
      p.bg_blue_diff = rand_byte();
      p.bg_red_diff = rand_byte();
      unused = key_mix(p, hit);
      if (!want_keyed || hit) begin
        break;
      end
    end
    return p;
  endfunction

  task automatic offer(input logic [7:0] fy, input logic [7:0] fu, input logic [7:0] fv,
                       input logic [7:0] by, input logic [7:0] bu, input logic [7:0] bv);
    pending_pixels.push_back('{fy, fu, fv, by, bu, bv});
    pixels_queued++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_KEY_CB_UNIT:         k_cb = int'($signed(val[7:0]));
      REG_KEY_CR_UNIT:         k_cr = int'($signed(val[7:0]));
      REG_ACCEPT_TANGENT:      k_tan = int'(val[11:0]);
      REG_ACCEPT_COTANGENT:    k_cot = int'(val[11:0]);
      REG_INVERSE_KEY_GAIN:    k_gain = int'($signed(val[8:0]));
      REG_LUMA_SUPPRESS_SCALE: k_scale = int'(val[7:0]);
      REG_KEY_MAGNITUDE:       k_mag = int'(val[8:0]);
      REG_NOISE_THRESHOLD:     k_thr = int'(val[15:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_key(input logic [15:0] cb, input logic [15:0] cr,
                          input logic [15:0] tan, input logic [15:0] cot,
                          input logic [15:0] gain, input logic [15:0] scale,
                          input logic [15:0] mag, input logic [15:0] thr);
    write_reg(REG_KEY_CB_UNIT, cb);
    write_reg(REG_KEY_CR_UNIT, cr);
    write_reg(REG_ACCEPT_TANGENT, tan);
    write_reg(REG_ACCEPT_COTANGENT, cot);
    write_reg(REG_INVERSE_KEY_GAIN, gain);
    write_reg(REG_LUMA_SUPPRESS_SCALE, scale);
    write_reg(REG_KEY_MAGNITUDE, mag);
    write_reg(REG_NOISE_THRESHOLD, thr);
  endtask

  task automatic wait_drained();
    while (pixels_checked != pixels_queued) begin
      @(negedge clk);
    end
  endtask

  always @(negedge clk) begin : feed
    if (rst_n) begin
      if (in_valid && !in_took) begin
        in_valid <= 1'b1;
      end else if (send_wait > 0) begin
        in_valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (pending_pixels.size() != 0) begin
        offered <= pending_pixels.pop_front();
        in_valid <= 1'b1;
        send_wait <= $urandom_range(0, send_idle_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : sink
    int k;
    if (rst_n) begin
      if (squeeze) begin
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait <= recv_wait - 1;
      end else if (out_ready && out_took) begin
        k = $urandom_range(0, recv_idle_max);
        out_ready <= (k == 0);
        if (k != 0) begin
          recv_wait <= k - 1;
        end
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : hold_off
    wait (squeeze_go);
    @(negedge clk);
    squeeze <= 1'b1;
    repeat (120) @(negedge clk);
    squeeze <= 1'b0;
  end

  always @(posedge clk) begin : watch
    keyed_pix_t want;
    bit hit;
    int bad;
    bad = 0;
    in_took <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = key_mix(offered, hit);
        expected_pixels.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected word: luma %0d cb %0d cr %0d", out_luma, out_blue_diff,
                 out_red_diff);
          bad++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_luma !== want.luma) begin
            $error("out_luma: expected %0d, got %0d", want.luma, out_luma);
            bad++;
          end
          if (out_blue_diff !== want.blue_diff) begin
            $error("out_blue_diff: expected %0d, got %0d", want.blue_diff, out_blue_diff);
            bad++;
          end
          if (out_red_diff !== want.red_diff) begin
            $error("out_red_diff: expected %0d, got %0d", want.red_diff, out_red_diff);
            bad++;
          end
          pixels_checked <= pixels_checked + 1;
        end
      end
    end
    mismatches <= mismatches + bad;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    offer(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    offer(8'd255, 8'd200, 8'd200, 8'd0, 8'd0, 8'd0);
    offer(8'd0, 8'd200, 8'd200, 8'd255, 8'd255, 8'd255);
    offer(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128);
    offer(8'd16, 8'd255, 8'd0, 8'd200, 8'd10, 8'd240);
    offer(8'd16, 8'd0, 8'd255, 8'd20, 8'd250, 8'd5);
    offer(8'd235, 8'd180, 8'd170, 8'd60, 8'd90, 8'd200);
    offer(8'd1, 8'd150, 8'd140, 8'd77, 8'd88, 8'd99);
    offer(8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255);
    offer(8'd255, 8'd40, 8'd60, 8'd0, 8'd255, 8'd0);
    wait_drained();

    load_key(16'd90, 16'd90, 16'd4, 16'd55, 16'hFF04, 16'd1, 16'd181, 16'hFFFF);
    offer(8'd50, 8'd200, 8'd200, 8'd10, 8'd240, 8'd128);
    offer(8'd200, 8'd180, 8'd170, 8'd255, 8'd255, 8'd255);
    offer(8'd0, 8'd255, 8'd250, 8'd0, 8'd0, 8'd0);
    offer(8'd0, 8'd0, 8'd255, 8'd33, 8'd44, 8'd55);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_key(16'd64, 16'd110, 16'd30, 16'd8, 16'd200, 16'd20, 16'd120, 16'd40);
        1: load_key(16'd127, 16'd127, 16'd4095, 16'd4095, 16'd255, 16'd255, 16'd511,
                    16'd65535);
        2: load_key(16'hFF81, 16'hFF81, 16'd0, 16'd0, 16'hFF01, 16'd0, 16'd0, 16'd0);
        3: load_key(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF);
        default: load_key(16'($urandom), 16'($urandom),
                          ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 64))
                                                      : 16'($urandom),
                          ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 64))
                                                      : 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom),
                          ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 300))
                                                      : 16'($urandom));
      endcase
      send_idle_max = (phase % 2 == 1) ? 0 : 19;
      recv_idle_max = (phase % 3 == 0) ? 0 : 19;
      for (int i = 0; i < 80; i++) begin
        pending_pixels.push_back(draw_pixel($urandom_range(0, 9) < 6));
        pixels_queued++;
      end
      if (phase == 1) begin
        squeeze_go = 1'b1;
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
